// ----- design/skew_line_closest_midpoint_top_assert.svh -----
// Assertion macros shared by the checker of the skew line closest point block.
// Depends on signals named clk and rst_n in the scope where a macro is used.
`ifndef SKEW_LINE_CLOSEST_MIDPOINT_TOP_ASSERT_SVH
`define SKEW_LINE_CLOSEST_MIDPOINT_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define SKLCM_AST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define SKLCM_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define SKLCM_AST_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/sklcm_pkg.sv -----
// Widths and constants of the skew line closest point pipeline.
// No dependencies; used by the top level and by the port checker.
package sklcm_pkg;

  localparam int COORD_W    = 32;
  localparam int IN_TDATA_W = 12 * COORD_W;
  localparam int OUT_TDATA_W = 4 * COORD_W;

  // Exact intermediate widths (signed unless noted).
  localparam int V_W   = COORD_W + 1;       // point sums, offsets, directions
  localparam int PR_W  = 2 * V_W;           // single products
  localparam int A2_W  = 68;                // dot products
  localparam int B2_W  = 67;                // dot products as multiplier operand
  localparam int P2_W  = A2_W + B2_W;       // second-order products
  localparam int N_W   = P2_W + 1;          // den, n1, n2
  localparam int P3_W  = N_W + V_W;         // third-order products
  localparam int E_W   = P3_W + 2;          // scaled numerators and gaps
  localparam int SQ_W  = 2 * E_W + 2;       // sum of squared gaps (unsigned)
  localparam int RT_W  = SQ_W / 2;          // its square root (unsigned)
  localparam int DEN_W = N_W;               // |den| (unsigned)
  localparam int NN_W  = RT_W;              // rounded dividend (unsigned)

  // Quotient bits kept by the two dividers.
  localparam int MID_QB = COORD_W;
  localparam int GAP_QB = COORD_W + 1;

  localparam logic [COORD_W-1:0] MID_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] MID_MIN = 32'h8000_0000;
  localparam logic [COORD_W-1:0] GAP_MAX = 32'hFFFF_FFFF;

endpackage

// ----- design/skew_line_closest_midpoint_top.sv -----
// Closest approach of two 3D lines, each given as a point and a direction in
// signed Q15.16. A fully pipelined datapath takes one input word per clock unless
// a result is stalled, and returns the rounded, saturated midpoint of the two
// closest points and half their distance, or the parallel flag with zero data
// when the denominator vanishes. The whole pipe holds when a result is stalled,
// and in_tready is high whenever the output register is empty or being drained.
// Most of the pipeline is the 172-stage square root of the summed squared gap
// and the 34-stage divider behind it.
// Depends on sklcm_pkg, sklcm_mul, sklcm_div, sklcm_sqrt and sklcm_dly.
module skew_line_closest_midpoint_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // p1_x, p1_y, p1_z, dir1_x, dir1_y, dir1_z, p2_x, p2_y, p2_z, dir2_x, dir2_y, dir2_z
  input  logic [sklcm_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // mid_x, mid_y, mid_z, half_gap
  output logic [sklcm_pkg::OUT_TDATA_W-1:0] out_tdata,
  // parallel
  output logic [0:0]                       out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready
);

  localparam int CW    = sklcm_pkg::COORD_W;
  localparam int V_W   = sklcm_pkg::V_W;
  localparam int PR_W  = sklcm_pkg::PR_W;
  localparam int A2_W  = sklcm_pkg::A2_W;
  localparam int B2_W  = sklcm_pkg::B2_W;
  localparam int P2_W  = sklcm_pkg::P2_W;
  localparam int N_W   = sklcm_pkg::N_W;
  localparam int P3_W  = sklcm_pkg::P3_W;
  localparam int E_W   = sklcm_pkg::E_W;
  localparam int SQ_W  = sklcm_pkg::SQ_W;
  localparam int RT_W  = sklcm_pkg::RT_W;
  localparam int DEN_W = sklcm_pkg::DEN_W;
  localparam int NN_W  = sklcm_pkg::NN_W;
  localparam int MQB   = sklcm_pkg::MID_QB;
  localparam int GQB   = sklcm_pkg::GAP_QB;

  // Unit latencies and stage positions.
  localparam int MUL2_LAT = (B2_W + 31) / 32 + 2;
  localparam int MUL3_LAT = (V_W + 31) / 32 + 2;
  localparam int MUL4_LAT = (E_W + 31) / 32 + 2;
  localparam int SQRT_LAT = SQ_W / 2;
  localparam int NDIV_LAT = MQB + 1;
  localparam int GDIV_LAT = GQB + 1;
  localparam int R4_OFS   = 3 + MUL2_LAT;
  localparam int R5_IDX   = R4_OFS + MUL3_LAT + 1;
  localparam int ROOT_OFS = MUL4_LAT + 1 + SQRT_LAT;
  localparam int GAP_OFS  = ROOT_OFS + GDIV_LAT + 1;
  localparam int MID_DLY  = GAP_OFS - 1 - (NDIV_LAT + 2);
  localparam int TOT      = R5_IDX + GAP_OFS + 1;

  logic           en;
  logic [TOT-1:0] vld_r;

  // Global stall: every stage moves when the output register can take a word.
  assign en         = !vld_r[TOT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[TOT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], in_tvalid};
    end
  end

  // Stage 1: offsets, point sums and sign-extended directions.
  logic signed [V_W-1:0] b_r [3], s_r [3], v1_r [3], v2_r [3];

  for (genvar k = 0; k < 3; k++) begin : g_r1
    logic signed [CW-1:0] p1, d1, p2, d2;
    always_comb begin
      p1 = $signed(in_tdata[CW*k +: CW]);
      d1 = $signed(in_tdata[CW*(3+k) +: CW]);
      p2 = $signed(in_tdata[CW*(6+k) +: CW]);
      d2 = $signed(in_tdata[CW*(9+k) +: CW]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        b_r[k]  <= V_W'(p2) - V_W'(p1);
        s_r[k]  <= V_W'(p2) + V_W'(p1);
        v1_r[k] <= V_W'(d1);
        v2_r[k] <= V_W'(d2);
      end
    end
  end

  // Stage 2: the fifteen single products of the dot products.
  logic signed [PR_W-1:0] q11_r [3], q22_r [3], q12_r [3], qb1_r [3], qb2_r [3];

  for (genvar k = 0; k < 3; k++) begin : g_r2
    always_ff @(posedge clk) begin
      if (en) begin
        q11_r[k] <= PR_W'(v1_r[k]) * PR_W'(v1_r[k]);
        q22_r[k] <= PR_W'(v2_r[k]) * PR_W'(v2_r[k]);
        q12_r[k] <= PR_W'(v1_r[k]) * PR_W'(v2_r[k]);
        qb1_r[k] <= PR_W'(b_r[k]) * PR_W'(v1_r[k]);
        qb2_r[k] <= PR_W'(b_r[k]) * PR_W'(v2_r[k]);
      end
    end
  end

  // Stage 3: dot products.
  logic signed [A2_W-1:0] a1_r, a2_r, a12_r, ab1_r, ab2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= A2_W'(q11_r[0]) + A2_W'(q11_r[1]) + A2_W'(q11_r[2]);
      a2_r  <= A2_W'(q22_r[0]) + A2_W'(q22_r[1]) + A2_W'(q22_r[2]);
      a12_r <= A2_W'(q12_r[0]) + A2_W'(q12_r[1]) + A2_W'(q12_r[2]);
      ab1_r <= A2_W'(qb1_r[0]) + A2_W'(qb1_r[1]) + A2_W'(qb1_r[2]);
      ab2_r <= A2_W'(qb2_r[0]) + A2_W'(qb2_r[1]) + A2_W'(qb2_r[2]);
    end
  end

  // Second-order products for den, n1 and n2.
  logic signed [P2_W-1:0] m_aa, m_a1a2, m_n1a, m_n1b, m_n2a, m_n2b;

  sklcm_mul #(.WA(A2_W), .WB(B2_W)) u_mul_aa (
    .clk(clk), .en(en), .a(a12_r), .b(B2_W'(a12_r)), .p(m_aa));
  sklcm_mul #(.WA(A2_W), .WB(B2_W)) u_mul_a1a2 (
    .clk(clk), .en(en), .a(a1_r), .b(B2_W'(a2_r)), .p(m_a1a2));
  sklcm_mul #(.WA(A2_W), .WB(B2_W)) u_mul_n1a (
    .clk(clk), .en(en), .a(ab2_r), .b(B2_W'(a12_r)), .p(m_n1a));
  sklcm_mul #(.WA(A2_W), .WB(B2_W)) u_mul_n1b (
    .clk(clk), .en(en), .a(ab1_r), .b(B2_W'(a2_r)), .p(m_n1b));
  sklcm_mul #(.WA(A2_W), .WB(B2_W)) u_mul_n2a (
    .clk(clk), .en(en), .a(ab2_r), .b(B2_W'(a1_r)), .p(m_n2a));
  sklcm_mul #(.WA(A2_W), .WB(B2_W)) u_mul_n2b (
    .clk(clk), .en(en), .a(ab1_r), .b(B2_W'(a12_r)), .p(m_n2b));

  // Stage 4: shared denominator and the two numerators.
  logic signed [N_W-1:0] den_r, n1_r, n2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= N_W'(m_aa) - N_W'(m_a1a2);
      n1_r  <= N_W'(m_n1a) - N_W'(m_n1b);
      n2_r  <= N_W'(m_n2a) - N_W'(m_n2b);
    end
  end

  // Per-axis vectors delayed to meet stage 4.
  logic [12*V_W-1:0] vec_in, vec_d;

  for (genvar k = 0; k < 3; k++) begin : g_pack
    assign vec_in[V_W*k +: V_W]     = b_r[k];
    assign vec_in[V_W*(3+k) +: V_W] = s_r[k];
    assign vec_in[V_W*(6+k) +: V_W] = v1_r[k];
    assign vec_in[V_W*(9+k) +: V_W] = v2_r[k];
  end

  sklcm_dly #(.W(12*V_W), .D(R4_OFS)) u_dly_vec (
    .clk(clk), .en(en), .din(vec_in), .dout(vec_d));

  // Third-order products and stage 5: scaled midpoint sums and gap vectors.
  logic signed [E_W-1:0] num_r [3], e_r [3];

  for (genvar k = 0; k < 3; k++) begin : g_r5
    logic signed [P3_W-1:0] t1, t2, sd, bd;
    sklcm_mul #(.WA(N_W), .WB(V_W)) u_mul_t1 (
      .clk(clk), .en(en), .a(n1_r), .b($signed(vec_d[V_W*(6+k) +: V_W])), .p(t1));
    sklcm_mul #(.WA(N_W), .WB(V_W)) u_mul_t2 (
      .clk(clk), .en(en), .a(n2_r), .b($signed(vec_d[V_W*(9+k) +: V_W])), .p(t2));
    sklcm_mul #(.WA(N_W), .WB(V_W)) u_mul_sd (
      .clk(clk), .en(en), .a(den_r), .b($signed(vec_d[V_W*(3+k) +: V_W])), .p(sd));
    sklcm_mul #(.WA(N_W), .WB(V_W)) u_mul_bd (
      .clk(clk), .en(en), .a(den_r), .b($signed(vec_d[V_W*k +: V_W])), .p(bd));
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= E_W'(sd) + E_W'(t1) + E_W'(t2);
        e_r[k]   <= E_W'(bd) - E_W'(t1) + E_W'(t2);
      end
    end
  end

  // Stage 5 side data: |den|, its sign and the parallel flag.
  logic signed [N_W-1:0] den_d;
  logic [DEN_W-1:0]      dabs_r;
  logic                  dneg_r, par_r;

  sklcm_dly #(.W(N_W), .D(MUL3_LAT)) u_dly_den (
    .clk(clk), .en(en), .din(den_r), .dout(den_d));

  always_ff @(posedge clk) begin
    if (en) begin
      dabs_r <= den_d[N_W-1] ? (~$unsigned(den_d) + 1'b1) : $unsigned(den_d);
      dneg_r <= den_d[N_W-1];
      par_r  <= (den_d == '0);
    end
  end

  // Midpoint path: round half away from zero by dividing |num| + |den| by 2|den|.
  logic [NN_W-1:0]  nn_r [3];
  logic [2:0]       nneg_r, nneg_d;
  logic [DEN_W:0]   dd_r;
  logic [CW-1:0]    mid_r [3];
  logic [3*CW-1:0]  mid_pk, mid_d;

  always_ff @(posedge clk) begin
    if (en) begin
      dd_r <= {dabs_r, 1'b0};
    end
  end

  sklcm_dly #(.W(3), .D(NDIV_LAT)) u_dly_nneg (
    .clk(clk), .en(en), .din(nneg_r), .dout(nneg_d));

  for (genvar k = 0; k < 3; k++) begin : g_mid
    logic [E_W-1:0] nmag;
    logic [MQB-1:0] q;
    logic           big;
    always_comb begin
      nmag = num_r[k][E_W-1] ? (~$unsigned(num_r[k]) + 1'b1) : $unsigned(num_r[k]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nn_r[k]   <= NN_W'(nmag) + NN_W'(dabs_r);
        nneg_r[k] <= num_r[k][E_W-1] ^ dneg_r;
      end
    end
    sklcm_div #(.WN(NN_W), .WD(DEN_W+1), .QB(MQB)) u_div_mid (
      .clk(clk), .en(en), .num(nn_r[k]), .den(dd_r), .q(q), .big(big));
    // Saturate to the signed coordinate range.
    always_ff @(posedge clk) begin
      if (en) begin
        if (nneg_d[k]) begin
          mid_r[k] <= (big || q > sklcm_pkg::MID_MIN) ? sklcm_pkg::MID_MIN : (CW'(0) - q);
        end else begin
          mid_r[k] <= (big || q[CW-1]) ? sklcm_pkg::MID_MAX : q;
        end
      end
    end
    assign mid_pk[CW*k +: CW] = mid_r[k];
  end

  sklcm_dly #(.W(3*CW), .D(MID_DLY)) u_dly_mid (
    .clk(clk), .en(en), .din(mid_pk), .dout(mid_d));

  // Gap path: sum of squared gap components, square root, divide by |den|.
  logic signed [2*E_W-1:0] ee [3];
  logic [SQ_W-1:0]         sumsq_r;
  logic [RT_W-1:0]         root;
  logic [DEN_W-1:0]        dabs_g;
  logic [GQB-1:0]          m;
  logic                    m_big;
  logic [GQB:0]            mp1;

  for (genvar k = 0; k < 3; k++) begin : g_sq
    sklcm_mul #(.WA(E_W), .WB(E_W)) u_mul_ee (
      .clk(clk), .en(en), .a(e_r[k]), .b(e_r[k]), .p(ee[k]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sumsq_r <= SQ_W'($unsigned(ee[0])) + SQ_W'($unsigned(ee[1]))
               + SQ_W'($unsigned(ee[2]));
    end
  end

  sklcm_sqrt #(.W(SQ_W)) u_sqrt (
    .clk(clk), .en(en), .rad(sumsq_r), .root(root));

  sklcm_dly #(.W(DEN_W), .D(ROOT_OFS)) u_dly_dabs (
    .clk(clk), .en(en), .din(dabs_r), .dout(dabs_g));

  sklcm_div #(.WN(RT_W), .WD(DEN_W), .QB(GQB)) u_div_gap (
    .clk(clk), .en(en), .num(root), .den(dabs_g), .q(m), .big(m_big));

  assign mp1 = (GQB+1)'(m) + 1'b1;

  // Parallel flag aligned with the output register.
  logic par_d;

  sklcm_dly #(.W(1), .D(GAP_OFS-1)) u_dly_par (
    .clk(clk), .en(en), .din(par_r), .dout(par_d));

  // Output register.
  logic [sklcm_pkg::OUT_TDATA_W-1:0] odata_r;
  logic                              opar_r;

  always_ff @(posedge clk) begin
    if (en) begin
      opar_r <= par_d;
      if (par_d) begin
        odata_r <= '0;
      end else begin
        odata_r[3*CW-1:0]     <= mid_d;
        odata_r[3*CW +: CW]   <= (m_big || mp1[GQB]) ? sklcm_pkg::GAP_MAX : mp1[CW:1];
      end
    end
  end

  assign out_tdata    = odata_r;
  assign out_tuser[0] = opar_r;

endmodule

// ----- design/sklcm_dly.sv -----
// Enable-gated delay line that keeps side data aligned with the arithmetic units.
// No dependencies.
module sklcm_dly #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [D];

  // Each tap takes the one before it when the pipeline moves.
  for (genvar i = 0; i < D; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[i] <= (i == 0) ? din : tap_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign dout = tap_r[D-1];

endmodule

// ----- design/sklcm_mul.sv -----
// Pipelined signed multiplier: one 32-bit limb of the second operand per stage,
// split against 32-bit pieces of the first. No dependencies.
module sklcm_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [WA-1:0]  a,
  input  logic signed [WB-1:0]  b,
  output logic signed [WA+WB-1:0] p
);

  localparam int K  = (WB + 31) / 32;
  localparam int KW = K * 32;
  localparam int KA = (WA + 31) / 32;
  localparam int AW = KA * 32;
  localparam int RW = AW + 32;
  localparam int PW = WA + WB;

  logic [AW-1:0] am_r [K+1];
  logic [KW-1:0] bm_r [K+1];
  logic          sg_r [K+1];
  logic [PW-1:0] acc_r [K+1];
  logic signed [PW-1:0] p_r;

  logic [WA-1:0] am_nxt;
  logic [WB-1:0] bm_nxt;

  // Sign and magnitude of the operands.
  always_comb begin
    am_nxt = a[WA-1] ? (~$unsigned(a) + 1'b1) : $unsigned(a);
    bm_nxt = b[WB-1] ? (~$unsigned(b) + 1'b1) : $unsigned(b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r[0]  <= AW'(am_nxt);
      bm_r[0]  <= KW'(bm_nxt);
      sg_r[0]  <= a[WA-1] ^ b[WB-1];
      acc_r[0] <= '0;
    end
  end

  // One limb row per stage: 32x32 products of every piece of the first operand,
  // even and odd pieces packed side by side so that neither group overlaps.
  for (genvar k = 0; k < K; k++) begin : g_limb
    logic [RW-1:0] ev, od;
    always_comb begin
      ev = '0;
      od = '0;
      for (int i = 0; i < KA; i++) begin
        if (i[0]) begin
          od[32*i +: 64] = 64'(am_r[k][32*i +: 32]) * 64'(bm_r[k][32*k +: 32]);
        end else begin
          ev[32*i +: 64] = 64'(am_r[k][32*i +: 32]) * 64'(bm_r[k][32*k +: 32]);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        am_r[k+1]  <= am_r[k];
        bm_r[k+1]  <= bm_r[k];
        sg_r[k+1]  <= sg_r[k];
        acc_r[k+1] <= acc_r[k] + (PW'(ev) << (32 * k)) + (PW'(od) << (32 * k));
      end
    end
  end

  // Restore the sign.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sg_r[K] ? $signed(~acc_r[K] + 1'b1) : $signed(acc_r[K]);
    end
  end

  assign p = p_r;

endmodule

// ----- design/sklcm_div.sv -----
// Pipelined restoring divider that keeps QB quotient bits and flags larger quotients.
// No dependencies.
module sklcm_div #(
  parameter int WN = 64,
  parameter int WD = 32,
  parameter int QB = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WN-1:0] num,
  input  logic [WD-1:0] den,
  output logic [QB-1:0] q,
  output logic          big
);

  localparam int WX = (WN > WD + QB) ? WN : WD + QB;

  logic [WX-1:0] r_r   [QB+1];
  logic [WD-1:0] d_r   [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          big_r [QB+1];

  // Entry: a quotient of 2^QB or more is only flagged.
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= WX'(num);
      d_r[0]   <= den;
      q_r[0]   <= '0;
      big_r[0] <= WX'(num) >= (WX'(den) << QB);
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 1; j <= QB; j++) begin : g_bit
    logic [WX-1:0] dsh;
    logic          take;
    always_comb begin
      dsh  = WX'(d_r[j-1]) << (QB - j);
      take = r_r[j-1] >= dsh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j]   <= take ? (r_r[j-1] - dsh) : r_r[j-1];
        d_r[j]   <= d_r[j-1];
        big_r[j] <= big_r[j-1];
        q_r[j]   <= q_r[j-1] | (take ? (QB'(1) << (QB - j)) : '0);
      end
    end
  end

  assign q   = q_r[QB];
  assign big = big_r[QB];

endmodule

// ----- design/sklcm_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// No dependencies; W even.
module sklcm_sqrt #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   rad,
  output logic [W/2-1:0] root
);

  localparam int H = W / 2;

  logic [W-1:0] n_r   [H];
  logic [W-1:0] res_r [H];

  // Stage j tries the bit of weight 4^(H-1-j).
  for (genvar j = 0; j < H; j++) begin : g_step
    logic [W-1:0] n_in, res_in, bitw, t;
    always_comb begin
      n_in   = (j == 0) ? rad : n_r[(j == 0) ? 0 : j - 1];
      res_in = (j == 0) ? '0  : res_r[(j == 0) ? 0 : j - 1];
      bitw   = W'(1) << (W - 2 - 2 * j);
      t      = res_in + bitw;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (n_in >= t) begin
          n_r[j]   <= n_in - t;
          res_r[j] <= (res_in >> 1) + bitw;
        end else begin
          n_r[j]   <= n_in;
          res_r[j] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_r[H-1][H-1:0];

endmodule

// ----- design/sklcm_chk.sv -----
// Port-level checker for the skew line closest point block, bound to the top level.
// Depends on sklcm_pkg and skew_line_closest_midpoint_top_assert.svh.
`include "skew_line_closest_midpoint_top_assert.svh"

module sklcm_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic [sklcm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [sklcm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]                        out_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  // A parallel result carries an all-zero word.
  `SKLCM_AST(a_par_zero, out_tvalid && out_tuser[0], out_tdata == '0, "parallel word not zero")

  // An empty output register never blocks the input.
  `SKLCM_AST(a_rdy_empty, !out_tvalid, in_tready, "input blocked with empty output")

  // A stalled result stays put.
  `SKLCM_AST_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled word changed")

  // Reset empties the pipeline.
  `SKLCM_AST_RST(a_rst, !rst_n, !out_tvalid, "valid word after reset")

endmodule

bind skew_line_closest_midpoint_top sklcm_chk u_sklcm_chk (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the closest approach block of two 3D lines.
// It sends directed and random line pairs, takes known answers or predicts with an
// exact wide-integer model of its own, and checks results. Depends on sklcm_pkg.
module testbench;

  typedef logic signed [399:0] wide_t;
  typedef logic [399:0] uwide_t;

  typedef struct {
    logic [31:0] mid_x;
    logic [31:0] mid_y;
    logic [31:0] mid_z;
    logic [31:0] half_gap;
    logic        parallel;
  } closest_t;

  typedef struct {
    logic [31:0] coord [12];
    bit          known;
    closest_t    answer;
  } line_pair_t;

  logic                              clk;
  logic                              rst_n;
  logic [sklcm_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [sklcm_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]                        out_tuser;
  logic                              out_tvalid;
  logic                              out_tready;

  closest_t pending_results[$];
  int       mismatches;
  bit       sink_steady;
  int       sink_hold;

  skew_line_closest_midpoint_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Free-running clock, period 10.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Integer square root, rounded down.
  function automatic uwide_t root_floor(uwide_t n);
    uwide_t res;
    uwide_t b;
    uwide_t t;
    res = '0;
    b = uwide_t'(1) << 398;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      t = res + b;
      if (n >= t) begin
        n = n - t;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Rounds num / (2*den) half away from zero and saturates to 32 bits.
  function automatic logic [31:0] mid_coord(wide_t num, uwide_t dabs, bit dneg);
    bit     neg;
    uwide_t mag;
    uwide_t q;
    neg = num[399] != dneg;
    mag = num[399] ? uwide_t'(-num) : uwide_t'(num);
    q = (mag + dabs) / (dabs << 1);
    if (neg) begin
      if (q > 64'h8000_0000) return sklcm_pkg::MID_MIN;
      return 32'(-q[31:0]);
    end
    if (q > 64'h7FFF_FFFF) return sklcm_pkg::MID_MAX;
    return q[31:0];
  endfunction

  // Exact closest-approach prediction for one line pair.
  function automatic closest_t closest_approach(logic [31:0] c [12]);
    closest_t r;
    wide_t  p1 [3];
    wide_t  v1 [3];
    wide_t  p2 [3];
    wide_t  v2 [3];
    wide_t  b [3];
    wide_t  a1, a2, a12, ab1, ab2, den, n1, n2, t1v, t2v, num, e;
    uwide_t dabs, sumsq, m;
    for (int k = 0; k < 3; k++) begin
      p1[k] = wide_t'($signed(c[k]));
      v1[k] = wide_t'($signed(c[3 + k]));
      p2[k] = wide_t'($signed(c[6 + k]));
      v2[k] = wide_t'($signed(c[9 + k]));
      b[k]  = p2[k] - p1[k];
    end
    a1  = v1[0] * v1[0] + v1[1] * v1[1] + v1[2] * v1[2];
    a2  = v2[0] * v2[0] + v2[1] * v2[1] + v2[2] * v2[2];
    a12 = v1[0] * v2[0] + v1[1] * v2[1] + v1[2] * v2[2];
    ab1 = b[0] * v1[0] + b[1] * v1[1] + b[2] * v1[2];
    ab2 = b[0] * v2[0] + b[1] * v2[1] + b[2] * v2[2];
    den = a12 * a12 - a1 * a2;
    r = '{default: '0};
    if (den == 0) begin
      r.parallel = 1'b1;
      return r;
    end
    n1 = ab2 * a12 - ab1 * a2;
    n2 = ab2 * a1 - ab1 * a12;
    dabs = den[399] ? uwide_t'(-den) : uwide_t'(den);
    sumsq = '0;
    for (int k = 0; k < 3; k++) begin
      t1v = n1 * v1[k];
      t2v = n2 * v2[k];
      num = (p1[k] + p2[k]) * den + t1v + t2v;
      e   = b[k] * den - t1v + t2v;
      sumsq = sumsq + uwide_t'(e * e);
      case (k)
        0: r.mid_x = mid_coord(num, dabs, den[399]);
        1: r.mid_y = mid_coord(num, dabs, den[399]);
        default: r.mid_z = mid_coord(num, dabs, den[399]);
      endcase
    end
    m = root_floor(sumsq) / dabs;
    m = (m + 1) >> 1;
    r.half_gap = (m > 64'hFFFF_FFFF) ? sklcm_pkg::GAP_MAX : m[31:0];
    return r;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // Sends one word and records its expected result once it is accepted.
  task automatic send_pair(line_pair_t item, bit no_gaps);
    int gap;
    for (int k = 0; k < 12; k++) in_tdata[32*k +: 32] <= item.coord[k];
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(item.known ? item.answer : closest_approach(item.coord));
    gap = no_gaps ? 0 : idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random coordinate: mostly modest Q15.16 values, sometimes any 32 bits.
  function automatic logic [31:0] rand_coord();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return $urandom;
    if (roll < 55) return 32'($signed($urandom_range(200, 0)) - 100) << 16;
    return 32'($signed($urandom_range(2000000, 0)) - 1000000) << 4;
  endfunction

  // Random line pair, with parallel and degenerate pairs mixed in.
  function automatic line_pair_t random_pair();
    line_pair_t item;
    int roll;
    int scale;
    item.known = 1'b0;
    item.answer = '{default: '0};
    for (int k = 0; k < 12; k++) item.coord[k] = rand_coord();
    roll = $urandom_range(99);
    if (roll < 8) begin
      scale = $signed($urandom_range(6, 0)) - 3;
      for (int k = 0; k < 3; k++) begin
        item.coord[3 + k] = 32'($signed($urandom_range(40, 0)) - 20) << 16;
        item.coord[9 + k] = item.coord[3 + k] * scale;
      end
    end else if (roll < 12) begin
      for (int k = 0; k < 3; k++) item.coord[(roll[0] ? 3 : 9) + k] = '0;
    end
    return item;
  endfunction

  function automatic line_pair_t directed(logic [31:0] c [12], bit known, closest_t ans);
    line_pair_t item;
    item.coord = c;
    item.known = known;
    item.answer = ans;
    return item;
  endfunction

  // Stimulus: reset, directed table, then random words.
  initial begin
    line_pair_t table_rows [$];
    closest_t   none;
    closest_t   flat;
    closest_t   unit_gap;
    logic [31:0] c [12];
    bit          steady;
    none = '{default: '0};
    flat = '{default: '0};
    flat.parallel = 1'b1;
    unit_gap = '{mid_x: 0, mid_y: 0, mid_z: 32'h0001_0000,
                 half_gap: 32'h0001_0000, parallel: 1'b0};

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatches = 0;
    sink_steady = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All zeros: degenerate lines.
    c = '{default: '0};
    table_rows.push_back(directed(c, 1'b1, flat));
    // Orthogonal unit lines two apart along z.
    c = '{0, 0, 0, 32'h1_0000, 0, 0, 0, 0, 32'h2_0000, 0, 32'h1_0000, 0};
    table_rows.push_back(directed(c, 1'b1, unit_gap));
    // Identical directions: parallel.
    c = '{5, 6, 7, 32'h3_0000, 32'h1_0000, 1, 9, 8, 7, 32'h3_0000, 32'h1_0000, 1};
    table_rows.push_back(directed(c, 1'b1, flat));
    // Opposite directions: parallel.
    c = '{0, 0, 0, 1, 2, 3, 4, 4, 4, -1, -2, -3};
    table_rows.push_back(directed(c, 1'b1, flat));
    // Zero direction on the second line.
    c = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 0, 0, 0};
    table_rows.push_back(directed(c, 1'b1, flat));
    // Field extremes, checked against the predictor.
    c = '{default: 32'h7FFF_FFFF};
    c[9] = 32'h8000_0000;
    table_rows.push_back(directed(c, 1'b0, none));
    c = '{default: 32'h8000_0000};
    c[4] = 32'h7FFF_FFFF;
    c[11] = 32'h0000_0001;
    table_rows.push_back(directed(c, 1'b0, none));
    c = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 0};
    table_rows.push_back(directed(c, 1'b0, none));
    // Huge offsets: large nearly parallel directions (saturating midpoint), then tiny ones.
    c = '{32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 0,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 1};
    table_rows.push_back(directed(c, 1'b0, none));
    c = '{0, 0, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 32'h8000_0000, 0, 1, 1};
    table_rows.push_back(directed(c, 1'b0, none));
    // Rounding ties in both signs, then lines meeting at a point.
    c = '{1, -1, 3, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 32'h1_0000, 0};
    table_rows.push_back(directed(c, 1'b0, none));
    c = '{-3, 1, -1, 32'h1_0000, 0, 0, 0, 0, -1, 0, 32'h1_0000, 0};
    table_rows.push_back(directed(c, 1'b0, none));
    // Intersecting lines: zero gap.
    c = '{32'h2_0000, 0, 0, -32'h1_0000, 0, 0, 0, 32'h2_0000, 0, 0, 32'h1_0000, 0};
    table_rows.push_back(directed(c, 1'b0, none));
    c = '{32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 32'h0000_FFFF,
          32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF, 32'h0F0F_0F0F,
          32'hF0F0_F0F0, 32'h0000_0003, 32'hFFFF_FFFD};
    table_rows.push_back(directed(c, 1'b0, none));

    foreach (table_rows[i]) send_pair(table_rows[i], 1'b0);

    // Random part, in stretches with and without input gaps chosen at random.
    steady = 1'b0;
    for (int n = 0; n < 800; n++) begin
      if (n % 100 == 0) steady = $urandom_range(2) == 0;
      // Let the pipe drain completely once in the middle.
      if (n == 400) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_pair(random_pair(), steady);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side back-pressure: steady stretches, short stalls and a few long ones.
  initial out_tready = 1'b0;
  always @(posedge clk) begin
    if ($urandom_range(199) == 0) sink_steady <= !sink_steady;
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (sink_steady) begin
      out_tready <= 1'b1;
    end else begin
      case ($urandom_range(99)) inside
        0: begin
          out_tready <= 1'b0;
          sink_hold <= $urandom_range(60, 15);
        end
        [1:19]: out_tready <= 1'b0;
        default: out_tready <= 1'b1;
      endcase
    end
  end

  // Checks each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    closest_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.mid_x) begin
          $error("mid_x expected %h actual %h", want.mid_x, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[63:32] !== want.mid_y) begin
          $error("mid_y expected %h actual %h", want.mid_y, out_tdata[63:32]);
          mismatches++;
        end
        if (out_tdata[95:64] !== want.mid_z) begin
          $error("mid_z expected %h actual %h", want.mid_z, out_tdata[95:64]);
          mismatches++;
        end
        if (out_tdata[127:96] !== want.half_gap) begin
          $error("half_gap expected %h actual %h", want.half_gap, out_tdata[127:96]);
          mismatches++;
        end
        if (out_tuser[0] !== want.parallel) begin
          $error("parallel expected %b actual %b", want.parallel, out_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
